[rtl/linear_interp_stereo_resampler_defines.svh]
// assertion helpers for the resampler checker
`ifndef LINEAR_INTERP_STEREO_RESAMPLER_DEFINES_SVH
`define LINEAR_INTERP_STEREO_RESAMPLER_DEFINES_SVH

// same-cycle implication, ignored while in reset
`define LISR_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lisr check failed");

// next-cycle implication, ignored while in reset
`define LISR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lisr check failed");

// next-cycle implication, checked through reset
`define LISR_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("lisr reset check failed");

`endif

[rtl/lisr_pkg.sv]
package lisr_pkg;

  localparam int PHASE_FRAC_BITS = 16;
  localparam int PHASE_W = PHASE_FRAC_BITS + 6;
  localparam int SAMPLE_W = 16;
  localparam int RATE_W = 21;
  localparam int PROD_W = PHASE_FRAC_BITS + 18;
  localparam int SCALE_W = PHASE_FRAC_BITS + 33;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(1) << PHASE_FRAC_BITS;
  localparam logic [PHASE_W-1:0] PHASE_TWO = PHASE_ONE << 1;
  localparam logic [PHASE_W-1:0] STEP_MIN = PHASE_ONE >> 5;

  localparam logic [CFG_IDX_W-1:0] REG_RATE_STEP = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MONO_SOURCE = 1'b1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] a_left;
    logic signed [SAMPLE_W-1:0] a_right;
    logic signed [SAMPLE_W-1:0] b_left;
    logic signed [SAMPLE_W-1:0] b_right;
    logic                       run_first;
    logic                       run_end;
  } lisr_job_t;

  function automatic logic [PHASE_W-1:0] lisr_eff_step(input logic [RATE_W-1:0] rate);
    logic [RATE_W+PHASE_FRAC_BITS-1:0] wide;
    logic [PHASE_W-1:0] s;
    wide = {rate, {PHASE_FRAC_BITS{1'b0}}} >> 16;
    s = wide[PHASE_W-1:0];
    return (s < STEP_MIN) ? STEP_MIN : s;
  endfunction

endpackage

[rtl/lisr_front.sv]
module lisr_front import lisr_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_left_sample,
  input  logic signed [SAMPLE_W-1:0] in_right_sample,
  input  logic                       in_block_end,
  input  logic                       mono_source,
  input  logic                       fifo_full,
  output logic                       push,
  output lisr_job_t                  push_job
);

  logic signed [SAMPLE_W-1:0] prev_left_r;
  logic signed [SAMPLE_W-1:0] prev_right_r;
  logic                       block_start_r;
  logic                       accept;
  logic signed [SAMPLE_W-1:0] right_eff;

  assign in_ready  = !fifo_full;
  assign accept    = in_valid && in_ready;
  assign right_eff = mono_source ? in_left_sample : in_right_sample;

  // first frame of a block only primes the history unless it also ends the block
  assign push = accept && (!block_start_r || in_block_end);

  always_comb begin
    push_job.a_left    = prev_left_r;
    push_job.a_right   = prev_right_r;
    push_job.b_left    = in_left_sample;
    push_job.b_right   = right_eff;
    push_job.run_first = !block_start_r;
    push_job.run_end   = in_block_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_start_r <= 1'b1;
    end else if (accept) begin
      block_start_r <= in_block_end;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prev_left_r  <= in_left_sample;
      prev_right_r <= right_eff;
    end
  end

endmodule

[rtl/lisr_fifo.sv]
module lisr_fifo import lisr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  lisr_job_t push_job,
  output logic      full,
  input  logic      pop,
  output lisr_job_t pop_job,
  output logic      empty
);

  lisr_job_t          mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r;
  logic [FIFO_AW-1:0] rd_ptr_r;
  logic [FIFO_AW:0]   cnt_r;
  logic               do_push;
  logic               do_pop;

  assign full    = (cnt_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

[rtl/lisr_back.sv]
module lisr_back import lisr_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [PHASE_W-1:0]         step,
  input  logic                       job_valid,
  input  lisr_job_t                  job,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_left,
  output logic signed [SAMPLE_W-1:0] out_right,
  output logic                       out_run_last
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN1 = 3'b010,
    ST_RUN2 = 3'b100
  } seq_state_t;

  seq_state_t                 state_r, state_nxt;
  logic [PHASE_W-1:0]         phase_r, phase_nxt;
  lisr_job_t                  job_r, job_nxt;

  logic                       s1_valid_r;
  logic signed [SAMPLE_W-1:0] s1_al_r, s1_bl_r, s1_ar_r, s1_br_r;
  logic [PHASE_FRAC_BITS-1:0] s1_f_r;
  logic                       s1_last_r;

  logic                       s2_valid_r;
  logic signed [SAMPLE_W-1:0] s2_al_r, s2_ar_r;
  logic signed [PROD_W-1:0]   s2_pl_r, s2_pr_r;
  logic                       s2_last_r;

  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_left_r, out_right_r;
  logic                       out_last_r;

  logic                       en;
  logic                       below;
  logic                       issue;
  logic                       issue_last;
  logic [PHASE_W-1:0]         nxt_pos;
  logic signed [SAMPLE_W-1:0] iss_al, iss_ar;

  function automatic logic signed [PROD_W-1:0] lisr_mul(
    input logic signed [SAMPLE_W-1:0] a,
    input logic signed [SAMPLE_W-1:0] b,
    input logic [PHASE_FRAC_BITS-1:0] f
  );
    logic signed [SAMPLE_W:0] diff;
    logic signed [PROD_W-1:0] prod;
    diff = $signed({b[SAMPLE_W-1], b}) - $signed({a[SAMPLE_W-1], a});
    prod = diff * $signed({1'b0, f});
    return prod;
  endfunction

  // (a*2^P + prod) * 32767 / 2^(P+15), truncated toward zero
  function automatic logic signed [SAMPLE_W-1:0] lisr_scale(
    input logic signed [SAMPLE_W-1:0] a,
    input logic signed [PROD_W-1:0]   prod
  );
    logic signed [PROD_W-1:0]  s;
    logic signed [SCALE_W-1:0] t;
    logic signed [SCALE_W-1:0] u;
    logic [SCALE_W-1:0]        bias;
    s = $signed({{2{a[SAMPLE_W-1]}}, a, {PHASE_FRAC_BITS{1'b0}}}) + prod;
    t = $signed({s, 15'b0}) - $signed({{15{s[PROD_W-1]}}, s});
    bias = t[SCALE_W-1] ?
      {{(SCALE_W-PHASE_FRAC_BITS-15){1'b0}}, {(PHASE_FRAC_BITS+15){1'b1}}} : '0;
    u = t + $signed(bias);
    return $signed(u[PHASE_FRAC_BITS+30:PHASE_FRAC_BITS+15]);
  endfunction

  assign en      = !out_valid_r || out_ready;
  assign below   = (phase_r < PHASE_ONE);
  assign nxt_pos = phase_r + step;

  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    job_nxt    = job_r;
    pop        = 1'b0;
    issue      = 1'b0;
    issue_last = 1'b0;
    iss_al     = job_r.a_left;
    iss_ar     = job_r.a_right;
    unique case (state_r)
      ST_IDLE: begin
        if (job_valid) begin
          pop       = 1'b1;
          job_nxt   = job;
          state_nxt = job.run_first ? ST_RUN1 : ST_RUN2;
        end
      end
      ST_RUN1: begin
        // last here only if the block-end interval will yield nothing
        issue_last = (nxt_pos >= PHASE_ONE) && (!job_r.run_end || nxt_pos >= PHASE_TWO);
        if (!below) begin
          phase_nxt = phase_r - PHASE_ONE;
          state_nxt = job_r.run_end ? ST_RUN2 : ST_IDLE;
        end else if (en) begin
          issue     = 1'b1;
          phase_nxt = nxt_pos;
        end
      end
      ST_RUN2: begin
        // block end: hold the last frame on both ends
        iss_al     = job_r.b_left;
        iss_ar     = job_r.b_right;
        issue_last = (nxt_pos >= PHASE_ONE);
        if (!below) begin
          phase_nxt = phase_r - PHASE_ONE;
          state_nxt = ST_IDLE;
        end else if (en) begin
          issue     = 1'b1;
          phase_nxt = nxt_pos;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= '0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      if (en) begin
        s1_valid_r  <= issue;
        s2_valid_r  <= s1_valid_r;
        out_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    if (en) begin
      s1_al_r     <= iss_al;
      s1_ar_r     <= iss_ar;
      s1_bl_r     <= job_r.b_left;
      s1_br_r     <= job_r.b_right;
      s1_f_r      <= phase_r[PHASE_FRAC_BITS-1:0];
      s1_last_r   <= issue_last;
      s2_al_r     <= s1_al_r;
      s2_ar_r     <= s1_ar_r;
      s2_pl_r     <= lisr_mul(s1_al_r, s1_bl_r, s1_f_r);
      s2_pr_r     <= lisr_mul(s1_ar_r, s1_br_r, s1_f_r);
      s2_last_r   <= s1_last_r;
      out_left_r  <= lisr_scale(s2_al_r, s2_pl_r);
      out_right_r <= lisr_scale(s2_ar_r, s2_pr_r);
      out_last_r  <= s2_last_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_left     = out_left_r;
  assign out_right    = out_right_r;
  assign out_run_last = out_last_r;

endmodule

[rtl/linear_interp_stereo_resampler.sv]
// channel   direction  handshake              payload
// in        input      in_valid / in_ready    in_left_sample, in_right_sample, in_block_end
// out       output     out_valid / out_ready  out_left, out_right, out_run_last
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one result per cycle from the interpolation pipe while the output is not stalled; the
// phase sequencer sets the pace, and it also stops to close each interval and to load each
// queued item; each issued position passes the s1, s2 and output registers
// reset is synchronous, active low; config is always ready
// a stalled output freezes the whole pipe; a four-item queue keeps input open
module linear_interp_stereo_resampler import lisr_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_left_sample,
  input  logic signed [SAMPLE_W-1:0] in_right_sample,
  input  logic                       in_block_end,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_left,
  output logic signed [SAMPLE_W-1:0] out_right,
  output logic                       out_run_last,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [RATE_W-1:0]          cfg_data
);

  logic [RATE_W-1:0]  rate_step_r;
  logic               mono_source_r;
  logic [PHASE_W-1:0] step;
  logic               fifo_full;
  logic               fifo_empty;
  logic               push;
  logic               pop;
  lisr_job_t          push_job;
  lisr_job_t          pop_job;

  assign cfg_ready = 1'b1;
  assign step      = lisr_eff_step(rate_step_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_step_r   <= RATE_W'(65536);
      mono_source_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_RATE_STEP:   rate_step_r   <= cfg_data;
        REG_MONO_SOURCE: mono_source_r <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  lisr_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_left_sample  (in_left_sample),
    .in_right_sample (in_right_sample),
    .in_block_end    (in_block_end),
    .mono_source     (mono_source_r),
    .fifo_full       (fifo_full),
    .push            (push),
    .push_job        (push_job)
  );

  lisr_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (fifo_full),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (fifo_empty)
  );

  lisr_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .job_valid    (!fifo_empty),
    .job          (pop_job),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_left     (out_left),
    .out_right    (out_right),
    .out_run_last (out_run_last)
  );

endmodule

[rtl/lisr_checker.sv]
`include "linear_interp_stereo_resampler_defines.svh"

module lisr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_left,
  input logic [15:0] out_right,
  input logic        out_run_last
);

  // scaled outputs never reach the most negative code
  `LISR_ASSERT_SAME(a_left_range, out_valid, out_left != 16'h8000)
  `LISR_ASSERT_SAME(a_right_range, out_valid, out_right != 16'h8000)

  `LISR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_left) && $stable(out_right) && $stable(out_run_last))

  // queue and pipe come up empty
  `LISR_ASSERT_RST(a_reset_clean, !rst_n, !out_valid && in_ready)

endmodule

bind linear_interp_stereo_resampler lisr_checker u_lisr_checker (.*);

[tb/sv/tb_linear_interp_stereo_resampler.sv]
`timescale 1ns / 1ps

module tb_linear_interp_stereo_resampler;
  import lisr_pkg::*;

  localparam longint FRAME_ONE = longint'(1) << PHASE_FRAC_BITS;
  localparam longint STEP_FLOOR = FRAME_ONE >> 5;
  localparam int MAX_PER_FRAME = 64;
  localparam int SETTLE_CYCLES = 300;
  localparam longint CYCLE_LIMIT = 5_000_000;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
    logic                       blk_end;
  } src_frame_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
    logic                       run_last;
  } out_frame_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [SAMPLE_W-1:0] in_left_sample = '0;
  logic signed [SAMPLE_W-1:0] in_right_sample = '0;
  logic in_block_end = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] out_left;
  logic signed [SAMPLE_W-1:0] out_right;
  logic out_run_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [RATE_W-1:0] cfg_data = '0;

  linear_interp_stereo_resampler dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_left_sample (in_left_sample),
    .in_right_sample(in_right_sample),
    .in_block_end   (in_block_end),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_left       (out_left),
    .out_right      (out_right),
    .out_run_last   (out_run_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #6 clk = ~clk;

  // predictor state
  logic [RATE_W-1:0] cur_rate = RATE_W'(65536);
  logic cur_mono = 1'b0;
  longint hist_left = 0;
  longint hist_right = 0;
  longint read_pos = 0;
  bit at_block_head = 1'b1;

  src_frame_t source_frames[$];
  out_frame_t span_results[$];
  out_frame_t resampled_q[$];
  src_frame_t next_frame;
  out_frame_t want;

  int frames_queued = 0;
  int frames_accepted = 0;
  int results_checked = 0;
  int reg_writes = 0;
  int fail_cnt = 0;
  longint cycles = 0;
  int src_gap = 0;
  int sink_gap = 0;
  bit src_steady = 1'b0;
  bit sink_steady = 1'b0;

  function automatic logic signed [SAMPLE_W-1:0] lerp_scaled(longint a, longint b, longint frac);
    longint num;
    longint mag;
    num = (a * FRAME_ONE + (b - a) * frac) * 32767;
    mag = (num < 0) ? -num : num;
    mag = mag >> (PHASE_FRAC_BITS + 15);
    return SAMPLE_W'((num < 0) ? -mag : mag);
  endfunction

  task automatic run_span(longint al, longint ar, longint bl, longint br, longint step);
    out_frame_t o;
    while (read_pos < FRAME_ONE && span_results.size() < MAX_PER_FRAME) begin
      o.left = lerp_scaled(al, bl, read_pos);
      o.right = lerp_scaled(ar, br, read_pos);
      o.run_last = 1'b0;
      span_results = {span_results, o};
      read_pos += step;
    end
    read_pos = (read_pos >= FRAME_ONE) ? read_pos - FRAME_ONE : 0;
  endtask

  task automatic predict_resample(logic signed [SAMPLE_W-1:0] l_in,
                                  logic signed [SAMPLE_W-1:0] r_in, logic e_in);
    longint l;
    longint r;
    longint step;
    out_frame_t o;
    l = l_in;
    r = cur_mono ? l : longint'(r_in);
    step = (longint'(cur_rate) << PHASE_FRAC_BITS) >> 16;
    if (step < STEP_FLOOR) step = STEP_FLOOR;
    span_results.delete();
    if (at_block_head) at_block_head = 1'b0;
    else run_span(hist_left, hist_right, l, r, step);
    hist_left = l;
    hist_right = r;
    if (e_in) begin
      run_span(l, r, l, r, step);
      at_block_head = 1'b1;
    end
    for (int i = 0; i < span_results.size(); i++) begin
      o = span_results[i];
      o.run_last = (i == span_results.size() - 1);
      resampled_q = {resampled_q, o};
    end
  endtask

  function automatic int pick_gap(bit steady);
    int r;
    r = $urandom_range(0, 99);
    if (steady) return 0;
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    int v;
    case ($urandom_range(0, 9))
      0: v = 32767;
      1: v = -32768;
      2: v = $urandom_range(0, 127) - 64;
      default: v = $urandom;
    endcase
    return v[SAMPLE_W-1:0];
  endfunction

  task automatic add_frame(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r,
                           logic e);
    src_frame_t f;
    f.left = l;
    f.right = r;
    f.blk_end = e;
    source_frames = {source_frames, f};
    frames_queued++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [RATE_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    reg_writes++;
    if (idx == REG_RATE_STEP) cur_rate = data;
    else if (idx == REG_MONO_SOURCE) cur_mono = data[0];
  endtask

  task automatic apply_cfg(logic [RATE_W-1:0] rate, logic mono);
    write_reg(REG_RATE_STEP, rate);
    write_reg(REG_MONO_SOURCE, RATE_W'(mono));
    @(negedge clk);
  endtask

  task automatic settle();
    do @(negedge clk); while (frames_accepted != frames_queued || resampled_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      src_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_resample(in_left_sample, in_right_sample, in_block_end);
        frames_accepted++;
      end
      if ($urandom_range(0, 63) == 0) src_steady <= !src_steady;
      if (!in_valid || in_ready) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          in_valid <= 1'b0;
        end else if (source_frames.size() > 0) begin
          next_frame = source_frames[0];
          source_frames.delete(0);
          in_left_sample <= next_frame.left;
          in_right_sample <= next_frame.right;
          in_block_end <= next_frame.blk_end;
          in_valid <= 1'b1;
          src_gap <= pick_gap(src_steady);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      sink_gap <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (resampled_q.size() == 0) begin
          $display("%0t: unexpected item left=%0d right=%0d run_last=%0b", $time,
                   out_left, out_right, out_run_last);
          fail_cnt++;
        end else begin
          want = resampled_q[0];
          resampled_q.delete(0);
          results_checked++;
          if (out_left !== want.left) begin
            $display("%0t: out_left expected %0d got %0d", $time, want.left, out_left);
            fail_cnt++;
          end
          if (out_right !== want.right) begin
            $display("%0t: out_right expected %0d got %0d", $time, want.right, out_right);
            fail_cnt++;
          end
          if (out_run_last !== want.run_last) begin
            $display("%0t: out_run_last expected %0b got %0b", $time, want.run_last,
                     out_run_last);
            fail_cnt++;
          end
        end
      end
      if ($urandom_range(0, 63) == 0) sink_steady <= !sink_steady;
      if (sink_gap > 0) begin
        sink_gap <= sink_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 2) == 0) sink_gap <= pick_gap(sink_steady);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d items outstanding", $time, resampled_q.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int n;
    int len;
    logic [RATE_W-1:0] rate;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings, full-scale swings, single-frame block
    add_frame(0, 0, 0);
    add_frame(32767, -32768, 0);
    add_frame(-32768, 32767, 0);
    add_frame(32767, 32767, 1);
    add_frame(-32768, -32768, 1);
    add_frame(1, -1, 0);
    settle();

    // smallest step, most results per item
    apply_cfg(RATE_W'(2048), 1'b0);
    add_frame(-32768, 32767, 1);
    add_frame(32767, -32768, 0);
    add_frame(0, 0, 1);
    settle();

    // zero step clamps, mono
    apply_cfg(RATE_W'(0), 1'b1);
    add_frame(12345, -5, 0);
    add_frame(-32768, 7, 0);
    add_frame(32767, 0, 1);
    add_frame(100, 200, 1);
    settle();

    apply_cfg(RATE_W'(2047), 1'b0);
    add_frame(-1, 1, 0);
    add_frame(5, -5, 1);
    settle();

    // largest step, mostly no results
    apply_cfg(RATE_W'(2097151), 1'b1);
    add_frame(32767, 1, 0);
    add_frame(-32768, 2, 0);
    add_frame(3, 4, 0);
    add_frame(5, 6, 0);
    add_frame(7, 8, 1);
    settle();

    for (int p = 0; p < 8; p++) begin
      case ($urandom_range(0, 7))
        0: rate = RATE_W'($urandom_range(2048, 8192));
        1: rate = RATE_W'($urandom_range(131072, 2097151));
        2: rate = RATE_W'($urandom_range(0, 2047));
        default: rate = RATE_W'($urandom_range(16384, 131072));
      endcase
      apply_cfg(rate, $urandom_range(0, 3) == 0);
      n = 0;
      while (n < 42) begin
        if ($urandom_range(0, 9) < 8) begin
          len = $urandom_range(1, 10);
          for (int k = 0; k < len; k++) add_frame(rand_sample(), rand_sample(), k == len - 1);
          n += len;
        end else begin
          add_frame(rand_sample(), rand_sample(), 1'($urandom_range(0, 1)));
          n++;
        end
      end
      settle();
    end

    $display("sent %0d source frames across %0d register writes", frames_accepted, reg_writes);
    $display("compared %0d resampled frames, %0d mismatches", results_checked, fail_cnt);
    if (fail_cnt == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

[linear_interp_stereo_resampler.f]
+incdir+rtl
rtl/lisr_pkg.sv
rtl/lisr_front.sv
rtl/lisr_fifo.sv
rtl/lisr_back.sv
rtl/linear_interp_stereo_resampler.sv
rtl/lisr_checker.sv
tb/sv/tb_linear_interp_stereo_resampler.sv
